/* rtl/icp_pkg.sv */
// Shared definitions for the interpolated color palette: operation and status
// codes, field widths and the queued item type.
// No dependencies; every other file in rtl/ uses this package.
`timescale 1ns / 1ps

package icp_pkg;

  localparam int MAX_ENTRIES_DEF = 256;

  localparam int COLOR_W = 8;
  localparam int POS_W   = 32;
  localparam int FRAC_W  = 8;
  localparam int MAG_W   = POS_W - 1;
  localparam int QUOT_W  = MAG_W - FRAC_W;
  localparam int ENTRY_W = 3 * COLOR_W;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_CHANGE = 2'd1;
  localparam logic [1:0] OP_INTERP = 2'd2;
  localparam logic [1:0] OP_GET    = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [COLOR_W-1:0] COLOR_MAX  = 8'hFF;
  localparam logic [COLOR_W-1:0] COLOR_ZERO = 8'h00;

  // One request after the front end has split the position into sign and
  // magnitude. The magnitude is the quotient (entry step) over the fraction.
  typedef struct packed {
    logic [1:0]         op;
    logic               neg;
    logic [MAG_W-1:0]   mag;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } icp_item_t;

endpackage

/* rtl/icp_front.sv */
// Front end of the palette: accepts request beats into a holding register,
// splits the position into sign and magnitude and pushes into the queue.
// Depends on icp_pkg.
`timescale 1ns / 1ps

module icp_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [1:0]                  operation,
  input  logic signed [icp_pkg::POS_W-1:0] position,
  input  logic [icp_pkg::COLOR_W-1:0] red,
  input  logic [icp_pkg::COLOR_W-1:0] green,
  input  logic [icp_pkg::COLOR_W-1:0] blue,
  input  logic                        q_full,
  output logic                        push,
  output icp_pkg::icp_item_t          item
);

  logic held;
  logic take;

  // The holding register drains whenever the queue has room, so it can take
  // a new beat in the same cycle.
  assign push      = held && !q_full;
  assign req_stall = held && q_full;
  assign take      = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.op    <= operation;
      item.neg   <= position[icp_pkg::POS_W-1];
      item.mag   <= position[icp_pkg::MAG_W-1:0];
      item.red   <= red;
      item.green <= green;
      item.blue  <= blue;
    end
  end

endmodule

/* rtl/icp_queue.sv */
// Two-entry queue between the palette front end and the back end.
// Depends on icp_pkg for the item type.
`timescale 1ns / 1ps

module icp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  icp_pkg::icp_item_t wr_item,
  input  logic               pop,
  output icp_pkg::icp_item_t head,
  output logic               full,
  output logic               empty
);

  localparam logic [1:0] DEPTH = 2'd2;

  icp_pkg::icp_item_t slot [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         level;
  logic               do_push;
  logic               do_pop;

  assign full    = (level == DEPTH);
  assign empty   = (level == 2'd0);
  assign head    = slot[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        level <= level + 2'd1;
      end else if (do_pop && !do_push) begin
        level <= level - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= wr_item;
    end
  end

endmodule

/* rtl/icp_back.sv */
// Back end of the palette: owns the entry memory and the entry count, runs
// each queued request (writes, exact reads, modulo divider and blend) and
// holds the response register. Depends on icp_pkg.
`timescale 1ns / 1ps

module icp_back #(
  parameter int MAX_ENTRIES = icp_pkg::MAX_ENTRIES_DEF,
  localparam int AW = $clog2(MAX_ENTRIES),
  localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  icp_pkg::icp_item_t          head,
  input  logic                        q_empty,
  output logic                        pop,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic [icp_pkg::COLOR_W-1:0] out_red,
  output logic [icp_pkg::COLOR_W-1:0] out_green,
  output logic [icp_pkg::COLOR_W-1:0] out_blue,
  output logic [1:0]                  status,
  output logic                        busy,
  output logic [CW-1:0]               entry_count
);

  localparam int DCW = $clog2(icp_pkg::QUOT_W);
  localparam logic [DCW-1:0] DIV_LAST = DCW'(icp_pkg::QUOT_W - 1);
  localparam logic [CW-1:0]  COUNT_MAX = CW'(MAX_ENTRIES);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DIV     = 3'd1;
  localparam logic [2:0] S_RD_BASE = 3'd2;
  localparam logic [2:0] S_RD_NEXT = 3'd3;
  localparam logic [2:0] S_BLEND   = 3'd4;
  localparam logic [2:0] S_EXACT   = 3'd5;
  localparam logic [2:0] S_OUT     = 3'd6;

  function automatic logic [icp_pkg::COLOR_W-1:0] blend(
    input logic [icp_pkg::COLOR_W-1:0] c1,
    input logic [icp_pkg::COLOR_W-1:0] c2,
    input logic [icp_pkg::FRAC_W-1:0]  f
  );
    logic [icp_pkg::COLOR_W-1:0]                  diff;
    logic [icp_pkg::COLOR_W+icp_pkg::FRAC_W-1:0] prod;
    if (c2 >= c1) begin
      diff  = c2 - c1;
      prod  = 16'(diff) * 16'(f);
      blend = c1 + prod[15:8];
    end else begin
      // Falling slope: round the drop up so the result floors.
      diff  = c1 - c2;
      prod  = 16'(diff) * 16'(f) + 16'(icp_pkg::COLOR_MAX);
      blend = c1 - prod[15:8];
    end
  endfunction

  logic [2:0]                    state;
  logic [CW-1:0]                 count;
  logic [icp_pkg::ENTRY_W-1:0]   mem [MAX_ENTRIES];
  logic [icp_pkg::ENTRY_W-1:0]   rdata;
  logic [CW-1:0]                 rem;
  logic [icp_pkg::QUOT_W-1:0]    quot;
  logic [DCW-1:0]                div_cnt;
  logic [icp_pkg::FRAC_W-1:0]    frac;
  logic [AW-1:0]                 nxt_addr;
  logic [icp_pkg::ENTRY_W-1:0]   c1;
  logic [icp_pkg::COLOR_W-1:0]   res_red;
  logic [icp_pkg::COLOR_W-1:0]   res_green;
  logic [icp_pkg::COLOR_W-1:0]   res_blue;
  logic [1:0]                    res_status;

  logic                          we;
  logic [AW-1:0]                 waddr;
  logic                          re;
  logic [AW-1:0]                 raddr;
  logic                          tbl_full;
  logic                          in_range;
  logic [CW:0]                   trial;
  logic                          trial_ge;
  logic [CW-1:0]                 rem_next;
  logic                          out_free;
  logic [CW-1:0]                 rem_inc;

  assign pop         = (state == S_IDLE) && !q_empty;
  assign busy        = (state != S_IDLE);
  assign entry_count = count;
  assign tbl_full    = (count == COUNT_MAX);
  assign in_range    = !head.neg && (head.mag < icp_pkg::MAG_W'(count));
  assign out_free    = !rsp_valid || !rsp_stall;

  // One restoring step of (quotient mod count) per cycle.
  assign trial    = {rem, quot[icp_pkg::QUOT_W-1]};
  assign trial_ge = trial >= {1'b0, count};
  assign rem_next = trial_ge ? CW'(trial - {1'b0, count}) : trial[CW-1:0];
  assign rem_inc  = rem + CW'(1);

  always_comb begin
    we    = 1'b0;
    waddr = count[AW-1:0];
    re    = 1'b0;
    raddr = rem[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          unique case (head.op)
            icp_pkg::OP_APPEND: begin
              we    = !tbl_full;
              waddr = count[AW-1:0];
            end
            icp_pkg::OP_CHANGE: begin
              we    = in_range;
              waddr = head.mag[AW-1:0];
            end
            icp_pkg::OP_GET: begin
              re    = in_range;
              raddr = head.mag[AW-1:0];
            end
            icp_pkg::OP_INTERP: begin
              re    = head.neg && (count != '0);
              raddr = AW'(count - CW'(1));
            end
            default: ;
          endcase
        end
      end
      S_RD_BASE: begin
        re    = 1'b1;
        raddr = rem[AW-1:0];
      end
      S_RD_NEXT: begin
        re    = 1'b1;
        raddr = nxt_addr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {head.red, head.green, head.blue};
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            unique case (head.op)
              icp_pkg::OP_APPEND: begin
                if (!tbl_full) begin
                  count <= count + CW'(1);
                end
                state <= S_OUT;
              end
              icp_pkg::OP_CHANGE: begin
                state <= S_OUT;
              end
              icp_pkg::OP_GET: begin
                state <= (count != '0 && in_range) ? S_EXACT : S_OUT;
              end
              icp_pkg::OP_INTERP: begin
                if (count == '0) begin
                  state <= S_OUT;
                end else if (head.neg) begin
                  state <= S_EXACT;
                end else begin
                  state <= S_DIV;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (div_cnt == DIV_LAST) begin
            state <= S_RD_BASE;
          end
        end
        S_RD_BASE: state <= S_RD_NEXT;
        S_RD_NEXT: state <= S_BLEND;
        S_BLEND:   state <= S_OUT;
        S_EXACT:   state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        rem     <= '0;
        div_cnt <= '0;
        quot    <= head.mag[icp_pkg::MAG_W-1:icp_pkg::FRAC_W];
        frac    <= head.mag[icp_pkg::FRAC_W-1:0];
        if (!q_empty) begin
          unique case (head.op)
            icp_pkg::OP_APPEND: begin
              res_red    <= icp_pkg::COLOR_ZERO;
              res_green  <= icp_pkg::COLOR_ZERO;
              res_blue   <= icp_pkg::COLOR_ZERO;
              res_status <= tbl_full ? icp_pkg::ST_FULL : icp_pkg::ST_OK;
            end
            icp_pkg::OP_CHANGE: begin
              res_red    <= icp_pkg::COLOR_ZERO;
              res_green  <= icp_pkg::COLOR_ZERO;
              res_blue   <= icp_pkg::COLOR_ZERO;
              res_status <= in_range ? icp_pkg::ST_OK : icp_pkg::ST_RANGE;
            end
            icp_pkg::OP_GET, icp_pkg::OP_INTERP: begin
              res_red    <= icp_pkg::COLOR_MAX;
              res_green  <= icp_pkg::COLOR_MAX;
              res_blue   <= icp_pkg::COLOR_MAX;
              res_status <= (count == '0) ? icp_pkg::ST_EMPTY : icp_pkg::ST_RANGE;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        rem     <= rem_next;
        quot    <= quot << 1;
        div_cnt <= div_cnt + DCW'(1);
      end
      S_RD_BASE: begin
        nxt_addr <= (rem_inc == count) ? '0 : rem_inc[AW-1:0];
      end
      S_RD_NEXT: begin
        c1 <= rdata;
      end
      S_BLEND: begin
        res_red    <= blend(c1[23:16], rdata[23:16], frac);
        res_green  <= blend(c1[15:8], rdata[15:8], frac);
        res_blue   <= blend(c1[7:0], rdata[7:0], frac);
        res_status <= icp_pkg::ST_OK;
      end
      S_EXACT: begin
        res_red    <= rdata[23:16];
        res_green  <= rdata[15:8];
        res_blue   <= rdata[7:0];
        res_status <= icp_pkg::ST_OK;
      end
      S_OUT: begin
        if (out_free) begin
          out_red   <= res_red;
          out_green <= res_green;
          out_blue  <= res_blue;
          status    <= res_status;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/interpolated_color_palette.sv */
// Interpolated color palette, top level.
// Request beats carry an operation, a position and a color. Every request beat
// produces exactly one response beat with a color and a status, in order.
// Append stores a color at the end of the table (status full when no room).
// Change rewrites an existing entry (status out of range otherwise). Get
// returns one entry; interpolate blends neighboring entries with 256 steps
// between them and wraps from the last entry to the first. Lookups on an
// empty table answer white with status empty; a negative interpolation index
// returns the last entry.
// Both channels use valid/stall; a beat moves when valid is high and stall is
// low. A front register takes request beats into a two-entry queue, and the
// back end works one request at a time. Append, change and any lookup that
// fails go straight to the response register; an in-range get and a negative
// interpolation index first read one entry. Interpolation runs the 23-step
// restoring divider that reduces the entry step modulo the entry count, two
// reads of the entry memory and a blend. The response register holds while
// stall is high and the back end waits on it; the front and queue keep taking
// beats until it fills. Synchronous reset empties the table and the queue;
// entry contents are not cleared, and only entries below the count are ever
// read.
`timescale 1ns / 1ps

module interpolated_color_palette #(
  parameter int MAX_ENTRIES = icp_pkg::MAX_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic [1:0]                       operation,
  input  logic signed [icp_pkg::POS_W-1:0] position,
  input  logic [icp_pkg::COLOR_W-1:0]      red,
  input  logic [icp_pkg::COLOR_W-1:0]      green,
  input  logic [icp_pkg::COLOR_W-1:0]      blue,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic [icp_pkg::COLOR_W-1:0]      out_red,
  output logic [icp_pkg::COLOR_W-1:0]      out_green,
  output logic [icp_pkg::COLOR_W-1:0]      out_blue,
  output logic [1:0]                       status
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  icp_pkg::icp_item_t front_item;
  icp_pkg::icp_item_t q_head;
  logic               front_push;
  logic               q_full;
  logic               q_empty;
  logic               back_pop;
  logic               back_busy;
  logic [CW-1:0]      entry_count;

  // Front end: one holding register that feeds the queue.
  icp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .operation (operation),
    .position  (position),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .q_full    (q_full),
    .push      (front_push),
    .item      (front_item)
  );

  // The queue lets the front keep taking beats while the back end divides
  // or waits on a stalled response.
  icp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (front_push),
    .wr_item (front_item),
    .pop     (back_pop),
    .head    (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Back end: owns the table and produces the response beat.
  icp_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .q_empty     (q_empty),
    .pop         (back_pop),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .status      (status),
    .busy        (back_busy),
    .entry_count (entry_count)
  );

`ifndef NO_ASSERTIONS
  // The table never holds more entries than it has room for.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(MAX_ENTRIES))
    else $error("entry count exceeds table size");

  // The count only grows, and by at most one entry per cycle.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (entry_count == $past(entry_count) ||
                     entry_count == $past(entry_count) + CW'(1)))
    else $error("entry count changed by an illegal step");

  // A response beat only appears after the back end was working on a request.
  a_rsp_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(back_busy))
    else $error("response raised without a request in the back end");
`endif

endmodule

/* tb/sv/interpolated_color_palette_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for interpolated_color_palette: random and directed
// palette requests, with a tracker class that predicts and checks every answer.
// Depends on rtl/icp_pkg.sv and rtl/interpolated_color_palette.sv.

module interpolated_color_palette_test;

  localparam int unsigned TABLE_SIZE   = icp_pkg::MAX_ENTRIES_DEF;
  localparam int          IDX_W        = $clog2(TABLE_SIZE);
  localparam int          RANDOM_BEATS = 1860;
  localparam int          IDLE_PCT     = 19;

  // One answer of the block: a color and its status code.
  typedef struct {
    logic [icp_pkg::COLOR_W-1:0] red;
    logic [icp_pkg::COLOR_W-1:0] green;
    logic [icp_pkg::COLOR_W-1:0] blue;
    logic [1:0]                  code;
  } palette_answer_t;

  // The tracker keeps its own copy of the palette. Every accepted request beat
  // is turned into the answer the block must give, and every response beat is
  // compared with the oldest answer still waiting.
  class palette_tracker;
    logic [icp_pkg::ENTRY_W-1:0] entries [TABLE_SIZE];
    int unsigned                 count;
    palette_answer_t             pending_answers[$];
    int                          errors;

    // Blend one channel: c1 plus the floor of (c2 - c1) * frac / 256.
    function automatic logic [icp_pkg::COLOR_W-1:0] mix_channel(
        logic [icp_pkg::COLOR_W-1:0] c1, logic [icp_pkg::COLOR_W-1:0] c2,
        logic [icp_pkg::FRAC_W-1:0] frac);
      int unsigned step;
      if (c2 >= c1) begin
        step = (32'(c2 - c1) * 32'(frac)) >> 8;
        return c1 + icp_pkg::COLOR_W'(step);
      end
      step = ((32'(c1 - c2) * 32'(frac)) + 32'd255) >> 8;
      return c1 - icp_pkg::COLOR_W'(step);
    endfunction

    function automatic void take_request(logic [1:0] op, logic [icp_pkg::POS_W-1:0] pos,
                                         logic [icp_pkg::COLOR_W-1:0] r,
                                         logic [icp_pkg::COLOR_W-1:0] g,
                                         logic [icp_pkg::COLOR_W-1:0] b);
      palette_answer_t             want;
      int unsigned                 base_idx;
      int unsigned                 next_idx;
      logic [icp_pkg::FRAC_W-1:0]  frac;
      logic [icp_pkg::ENTRY_W-1:0] lo;
      logic [icp_pkg::ENTRY_W-1:0] hi;
      want = '{icp_pkg::COLOR_ZERO, icp_pkg::COLOR_ZERO, icp_pkg::COLOR_ZERO,
               icp_pkg::ST_OK};
      case (op)
        icp_pkg::OP_APPEND: begin
          if (count >= TABLE_SIZE) begin
            want.code = icp_pkg::ST_FULL;
          end else begin
            entries[IDX_W'(count)] = {r, g, b};
            count++;
          end
        end
        icp_pkg::OP_CHANGE: begin
          if (pos[icp_pkg::POS_W-1] || pos >= count) begin
            want.code = icp_pkg::ST_RANGE;
          end else begin
            entries[IDX_W'(pos)] = {r, g, b};
          end
        end
        default: begin
          if (count == 0) begin
            want = '{icp_pkg::COLOR_MAX, icp_pkg::COLOR_MAX, icp_pkg::COLOR_MAX,
                     icp_pkg::ST_EMPTY};
          end else if (op == icp_pkg::OP_GET) begin
            if (pos[icp_pkg::POS_W-1] || pos >= count) begin
              want = '{icp_pkg::COLOR_MAX, icp_pkg::COLOR_MAX, icp_pkg::COLOR_MAX,
                       icp_pkg::ST_RANGE};
            end else begin
              {want.red, want.green, want.blue} = entries[IDX_W'(pos)];
            end
          end else if (pos[icp_pkg::POS_W-1]) begin
            {want.red, want.green, want.blue} = entries[IDX_W'(count - 1)];
          end else begin
            base_idx = (pos >> icp_pkg::FRAC_W) % count;
            next_idx = (base_idx + 1) % count;
            frac     = pos[icp_pkg::FRAC_W-1:0];
            lo       = entries[IDX_W'(base_idx)];
            hi       = entries[IDX_W'(next_idx)];
            want.red   = mix_channel(lo[23:16], hi[23:16], frac);
            want.green = mix_channel(lo[15:8], hi[15:8], frac);
            want.blue  = mix_channel(lo[7:0], hi[7:0], frac);
          end
        end
      endcase
      pending_answers.push_back(want);
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function automatic void match_answer(logic [icp_pkg::COLOR_W-1:0] r,
                                         logic [icp_pkg::COLOR_W-1:0] g,
                                         logic [icp_pkg::COLOR_W-1:0] b, logic [1:0] st);
      palette_answer_t want;
      if (pending_answers.size() == 0) begin
        errors++;
        $display("%0t: response beat with no request waiting, actual %0d %0d %0d status %0d",
                 $time, r, g, b, st);
        return;
      end
      want = pending_answers.pop_front();
      compare_field("out_red", 32'(want.red), 32'(r));
      compare_field("out_green", 32'(want.green), 32'(g));
      compare_field("out_blue", 32'(want.blue), 32'(b));
      compare_field("status", 32'(want.code), 32'(st));
    endfunction
  endclass

  logic                               clk;
  logic                               rst       = 1'b1;
  logic                               req_valid = 1'b0;
  logic                               req_stall;
  logic [1:0]                         operation = icp_pkg::OP_APPEND;
  logic signed [icp_pkg::POS_W-1:0]   position  = '0;
  logic [icp_pkg::COLOR_W-1:0]        red       = '0;
  logic [icp_pkg::COLOR_W-1:0]        green     = '0;
  logic [icp_pkg::COLOR_W-1:0]        blue      = '0;
  logic                               rsp_valid;
  logic                               rsp_stall = 1'b0;
  logic [icp_pkg::COLOR_W-1:0]        out_red;
  logic [icp_pkg::COLOR_W-1:0]        out_green;
  logic [icp_pkg::COLOR_W-1:0]        out_blue;
  logic [1:0]                         status;

  palette_tracker tracker = new;

  // The sender and the receiver each have a window with no idling at all.
  bit steady_send = 1'b0;
  int answers_seen = 0;

  interpolated_color_palette u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .operation (operation),
    .position  (position),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .status    (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random, changing its mind only at the falling edge,
  // except while answers 700 to 1000 come through.
  always @(negedge clk) begin
    if (answers_seen >= 700 && answers_seen < 1000) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Response beats are taken at the rising edge, where valid and stall are
  // both settled from the previous falling edge.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      tracker.match_answer(out_red, out_green, out_blue, status);
      answers_seen <= answers_seen + 1;
    end
  end

  // Sends one request beat. Starts and ends just after a rising edge. Idle
  // cycles are inserted one at a time, so roughly a fifth of the cycles idle.
  // Valid is written once per falling edge, so it never drops and rises in the
  // same time step.
  task automatic send_beat(logic [1:0] op, logic [icp_pkg::POS_W-1:0] pos,
                           logic [icp_pkg::COLOR_W-1:0] r, logic [icp_pkg::COLOR_W-1:0] g,
                           logic [icp_pkg::COLOR_W-1:0] b);
    while (!steady_send && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      req_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    req_valid <= 1'b1;
    operation <= op;
    position  <= pos;
    red       <= r;
    green     <= g;
    blue      <= b;
    do @(posedge clk); while (req_stall);
    tracker.take_request(op, pos, r, g, b);
  endtask

  // Channel values lean toward the extremes now and then, so that blends of
  // 0 against 255 in both directions turn up often.
  function automatic logic [icp_pkg::COLOR_W-1:0] pick_channel();
    case ($urandom_range(9))
      0: return icp_pkg::COLOR_ZERO;
      1: return icp_pkg::COLOR_MAX;
      default: return icp_pkg::COLOR_W'($urandom_range(255));
    endcase
  endfunction

  // Positions for change and get: mostly live entries, some just past the
  // end, some negative, and a few anywhere in the 32-bit range.
  function automatic logic [icp_pkg::POS_W-1:0] pick_entry_position();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70 && tracker.count > 0) begin
      return $urandom_range(tracker.count - 1);
    end else if (roll < 85) begin
      return tracker.count + $urandom_range(3);
    end else if (roll < 95) begin
      return $urandom | 32'h8000_0000;
    end
    return $urandom;
  endfunction

  // Color indexes: half within two laps of the table, so that the wrap from
  // the last entry to the first is hit, plus large, negative and raw values.
  function automatic logic [icp_pkg::POS_W-1:0] pick_color_index();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50) begin
      return $urandom_range((tracker.count + 1) * 512);
    end else if (roll < 70) begin
      return $urandom & 32'h7FFF_FFFF;
    end else if (roll < 80) begin
      return $urandom | 32'h8000_0000;
    end
    return $urandom;
  endfunction

  initial begin
    int unsigned                roll;
    logic [1:0]                 op;
    logic [icp_pkg::POS_W-1:0]  pos;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Lookups and changes on an empty table come first.
    send_beat(icp_pkg::OP_GET,    32'd0,         8'd1, 8'd2, 8'd3);
    send_beat(icp_pkg::OP_INTERP, 32'd0,         8'd0, 8'd0, 8'd0);
    send_beat(icp_pkg::OP_INTERP, 32'hFFFF_FFFF, 8'd0, 8'd0, 8'd0);
    send_beat(icp_pkg::OP_CHANGE, 32'd0,         8'd9, 8'd9, 8'd9);
    // A single entry blends with itself, even at the largest index.
    send_beat(icp_pkg::OP_APPEND, 32'd0,
              icp_pkg::COLOR_ZERO, icp_pkg::COLOR_ZERO, icp_pkg::COLOR_ZERO);
    send_beat(icp_pkg::OP_INTERP, 32'h7FFF_FFFF, 8'd0, 8'd0, 8'd0);
    send_beat(icp_pkg::OP_APPEND, 32'hFFFF_FFFF,
              icp_pkg::COLOR_MAX, icp_pkg::COLOR_MAX, icp_pkg::COLOR_MAX);
    send_beat(icp_pkg::OP_APPEND, 32'h8000_0000,
              icp_pkg::COLOR_ZERO, icp_pkg::COLOR_MAX, 8'h5A);
    // Rising and falling slopes at the top fraction, then the wrap around.
    send_beat(icp_pkg::OP_INTERP, 32'h0000_00FF, 8'd0, 8'd0, 8'd0);
    send_beat(icp_pkg::OP_INTERP, 32'h0000_01FF, 8'd0, 8'd0, 8'd0);
    send_beat(icp_pkg::OP_INTERP, 32'h0000_0280, 8'd0, 8'd0, 8'd0);
    send_beat(icp_pkg::OP_INTERP, 32'h0000_017F, 8'd0, 8'd0, 8'd0);
    // Negative color indexes return the last entry exactly.
    send_beat(icp_pkg::OP_INTERP, 32'h8000_0000, 8'd0, 8'd0, 8'd0);
    send_beat(icp_pkg::OP_INTERP, 32'hFFFF_FFFF, 8'd0, 8'd0, 8'd0);
    // Exact reads in and out of range.
    send_beat(icp_pkg::OP_GET,    32'd2,         8'd0, 8'd0, 8'd0);
    send_beat(icp_pkg::OP_GET,    32'd3,         8'd0, 8'd0, 8'd0);
    send_beat(icp_pkg::OP_GET,    32'hFFFF_FFFF, 8'd0, 8'd0, 8'd0);
    send_beat(icp_pkg::OP_GET,    32'h8000_0000, 8'd0, 8'd0, 8'd0);
    // Changes in and out of range.
    send_beat(icp_pkg::OP_CHANGE, 32'd1,         8'h12, 8'h34, 8'h56);
    send_beat(icp_pkg::OP_CHANGE, 32'd3,         8'hAA, 8'hBB, 8'hCC);
    send_beat(icp_pkg::OP_CHANGE, -32'sd5,       8'hAA, 8'hBB, 8'hCC);
    send_beat(icp_pkg::OP_CHANGE, 32'h7FFF_FFFF, 8'hAA, 8'hBB, 8'hCC);
    send_beat(icp_pkg::OP_GET,    32'd1,         8'd0, 8'd0, 8'd0);

    // Random part. Appends are rare enough that the table grows slowly: small
    // tables get exercised early and the full table late in the run.
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      steady_send = (i >= 700 && i < 1000);
      roll = $urandom_range(99);
      if (roll < 18) begin
        op = icp_pkg::OP_APPEND;
      end else if (roll < 38) begin
        op = icp_pkg::OP_CHANGE;
      end else if (roll < 70) begin
        op = icp_pkg::OP_INTERP;
      end else begin
        op = icp_pkg::OP_GET;
      end
      pos = (op == icp_pkg::OP_INTERP) ? pick_color_index() : pick_entry_position();
      send_beat(op, pos, pick_channel(), pick_channel(), pick_channel());
    end
    steady_send = 1'b0;

    // Make sure the table fills, then push past it and read around the top.
    while (tracker.count < TABLE_SIZE) begin
      send_beat(icp_pkg::OP_APPEND, $urandom, pick_channel(), pick_channel(),
                pick_channel());
    end
    repeat (3) send_beat(icp_pkg::OP_APPEND, $urandom, pick_channel(), pick_channel(),
                         pick_channel());
    send_beat(icp_pkg::OP_GET,    TABLE_SIZE - 1, 8'd0, 8'd0, 8'd0);
    send_beat(icp_pkg::OP_GET,    TABLE_SIZE,     8'd0, 8'd0, 8'd0);
    send_beat(icp_pkg::OP_INTERP, 32'h0000_FFFF,  8'd0, 8'd0, 8'd0);
    send_beat(icp_pkg::OP_INTERP, 32'hFFFF_FFFF,  8'd0, 8'd0, 8'd0);

    @(negedge clk);
    req_valid <= 1'b0;

    // Drain every outstanding answer, then give the block time to show any
    // stray response beat.
    while (tracker.pending_answers.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Safety net: a correct run needs well under a tenth of this time.
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
